>>> hw/rtl/ridat_pkg.sv
`timescale 1ns / 1ps
package ridat_pkg;

    localparam int MAX_REQUESTS_DEF      = 64;
    localparam int MAX_PAYLOAD_WORDS_DEF = 8;

    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_SETLOC  = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_PWRITE  = 3'd4;
    localparam logic [2:0] OP_PREAD   = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFREE  = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_FREEREL = 3'd3;
    localparam logic [2:0] ST_INVAR   = 3'd4;

    localparam logic [0:0] CFG_ACTIVE  = 1'b0;
    localparam logic [0:0] CFG_PWORDS  = 1'b1;

    // entry fields as stored
    typedef struct packed {
        logic [7:0]  etype;
        logic [7:0]  eflag;
        logic [7:0]  hop;
        logic [2:0]  loc_type;
        logic [15:0] loc_id;
        logic [15:0] slot;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic init_start;   // restart the clearing sweep
        logic init_step;    // clear one row and one free-stack slot
        logic load;         // capture incoming word and decode
        logic rd;           // registered reads of the target entry
        logic commit;       // apply the op to the stores
        logic clr_step;     // clear one payload word
        logic out_load;     // form the result word
    } ridat_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic init_done;
        logic need_clear;
        logic clr_done;
    } ridat_sts_t;

    function automatic logic inv_ok(input logic [2:0] lt, input logic [15:0] loc,
                                    input logic [15:0] slot);
        logic slot_none;
        slot_none = (slot == 16'hFFFF);
        case (lt)
            3'd0:    inv_ok = (loc == 16'hFFFF) && slot_none;
            3'd1:    inv_ok = !loc[15] && !slot[15];
            3'd2:    inv_ok = !loc[15] && slot_none;
            3'd3:    inv_ok = !loc[15] && slot_none;
            3'd4:    inv_ok = slot_none;
            default: inv_ok = 1'b0;
        endcase
    endfunction

endpackage

>>> hw/rtl/ridat_ctrl.sv
`timescale 1ns / 1ps
module ridat_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr,
    input  logic                 s_fire,
    input  logic                 m_busy,
    input  ridat_pkg::ridat_sts_t sts,
    output ridat_pkg::ridat_cmd_t cmd,
    output logic                 s_ready,
    output logic                 out_set
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_CLR   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        out_set = 1'b0;
        cmd.init_start = !aresetn || cfg_wr;
        case (state_reg)
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (sts.init_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = !m_busy;
                cmd.load = s_fire;
                if (s_fire) state_next = S_RD;
            end
            S_RD: begin
                cmd.rd = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.commit = 1'b1;
                cmd.out_load = 1'b1;
                state_next = sts.need_clear ? S_CLR : S_OUT;
            end
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) state_next = S_OUT;
            end
            S_OUT: begin
                out_set = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_INIT;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> state_reg == S_IDLE) else $error("word taken outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD && !cfg_wr) |=> state_reg == S_EXEC)
        else $error("read not followed by exec");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_set |-> !m_busy) else $error("result overwritten");

endmodule

>>> hw/rtl/ridat_dp.sv
`timescale 1ns / 1ps
module ridat_dp #(
    parameter int ID_COUNT          = ridat_pkg::MAX_REQUESTS_DEF,
    parameter int MAX_PAYLOAD_WORDS = ridat_pkg::MAX_PAYLOAD_WORDS_DEF
) (
    input  logic                  aclk,
    input  logic                  cfg_wr,
    input  logic                  cfg_idx,
    input  logic [6:0]            cfg_val,
    input  logic                  aresetn,
    input  ridat_pkg::ridat_cmd_t cmd,
    output ridat_pkg::ridat_sts_t sts,
    input  logic [2:0]            in_op,
    input  logic [7:0]            in_rid,
    input  logic [7:0]            in_type,
    input  logic [7:0]            in_flag,
    input  logic [2:0]            in_lt,
    input  logic [15:0]           in_lid,
    input  logic [15:0]           in_slot,
    input  logic [2:0]            in_widx,
    input  logic [31:0]           in_wdata,
    output logic [2:0]            o_status,
    output logic [6:0]            o_rid,
    output ridat_pkg::entry_t     o_entry,
    output logic [15:0]           o_gen,
    output logic                  o_alloc,
    output logic [31:0]           o_rdata
);

    localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int WW = (MAX_PAYLOAD_WORDS > 1) ? $clog2(MAX_PAYLOAD_WORDS) : 1;
    localparam int DEPTH = ID_COUNT * (1 << WW);
    localparam int AW = IW + WW;
    localparam ridat_pkg::entry_t ENTRY_RST =
        '{etype: 8'd0, eflag: 8'd0, hop: 8'd0, loc_type: 3'd0,
          loc_id: 16'hFFFF, slot: 16'hFFFF};

    // payload is laid out as id * 2^WW + word, clear limited to the configured word count
    logic [31:0] pay_mem [DEPTH];
    logic [IW-1:0] stack_mem [ID_COUNT];
    ridat_pkg::entry_t entry_mem [ID_COUNT];
    logic [15:0] gen_mem [ID_COUNT];
    logic alloc_mem [ID_COUNT];

    logic [6:0] active_reg;
    logic [3:0] pwords_reg;
    logic [IW:0] free_reg;
    logic [AW:0] init_cnt_reg;
    logic [WW:0] clr_cnt_reg;

    logic [2:0]  op_reg;
    logic [7:0]  rid_reg;
    logic [7:0]  type_reg, flag_reg;
    logic [2:0]  lt_reg;
    logic [15:0] lid_reg, slot_reg;
    logic [2:0]  widx_reg;
    logic [31:0] wdata_reg;
    logic [IW-1:0] id_reg;
    logic        bad_reg, nofree_reg, widx_bad_reg;

    ridat_pkg::entry_t ent_rd_reg;
    logic [15:0] gen_rd_reg;
    logic [31:0] pay_rd_reg;
    logic [IW-1:0] pop_rd_reg;
    logic        alloc_rd_reg;

    logic [6:0] act_sat;
    logic [3:0] pw_sat;
    logic [IW:0] free_m1;
    logic [IW-1:0] tgt;
    logic [7:0] act_ext;
    logic is_alloc, rel_ok;
    logic [WW-1:0] widx_n;

    logic [2:0]        status_next;
    logic [6:0]        rid_next;
    ridat_pkg::entry_t entry_next;
    logic [15:0]       gen_next;
    logic              alloc_next;
    logic [31:0]       rdata_next;

    always_comb begin
        act_sat = (cfg_val == 7'd0) ? 7'd1 : cfg_val;
        if (32'(act_sat) > ID_COUNT) act_sat = 7'(ID_COUNT);
        pw_sat = (cfg_val[3:0] == 4'd0) ? 4'd1 : cfg_val[3:0];
        if (32'(pw_sat) > MAX_PAYLOAD_WORDS) pw_sat = 4'(MAX_PAYLOAD_WORDS);
    end

    assign free_m1 = free_reg - 1'b1;
    assign act_ext = {1'b0, active_reg};
    assign widx_n  = WW'(widx_reg);
    assign is_alloc = (op_reg == ridat_pkg::OP_ALLOC);
    assign tgt = is_alloc ? pop_rd_reg : id_reg;
    assign rel_ok = (op_reg == ridat_pkg::OP_RELEASE) && !bad_reg && alloc_rd_reg;

    assign sts.init_done = (init_cnt_reg == (AW+1)'(DEPTH - 1));
    assign sts.need_clear = (is_alloc && !nofree_reg) || rel_ok;
    assign sts.clr_done = ((WW+1)'(clr_cnt_reg + 1'b1) >= (WW+1)'(pwords_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 7'(ID_COUNT);
            pwords_reg <= 4'(MAX_PAYLOAD_WORDS);
        end else if (cfg_wr) begin
            if (cfg_idx == ridat_pkg::CFG_ACTIVE) active_reg <= act_sat;
            else pwords_reg <= pw_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init_start) begin
            init_cnt_reg <= '0;
        end else if (cmd.init_step && !sts.init_done) begin
            init_cnt_reg <= init_cnt_reg + 1'b1;
        end
        if (cmd.init_step) begin
            pay_mem[init_cnt_reg[AW-1:0]] <= '0;
        end else if (cmd.clr_step) begin
            pay_mem[{tgt, clr_cnt_reg[WW-1:0]}] <= '0;
        end else if (cmd.commit && op_reg == ridat_pkg::OP_PWRITE && !bad_reg
                     && !widx_bad_reg) begin
            pay_mem[{id_reg, widx_n}] <= wdata_reg;
        end
        if (cmd.rd) pay_rd_reg <= pay_mem[{id_reg, widx_n}];
    end

    // free stack, entry, generation and allocated-flag stores
    always_ff @(posedge aclk) begin
        if (cmd.init_step && init_cnt_reg < (AW+1)'(ID_COUNT)) begin
            stack_mem[init_cnt_reg[IW-1:0]] <=
                IW'(act_ext - 8'd1 - 8'(init_cnt_reg));
            entry_mem[init_cnt_reg[IW-1:0]] <= ENTRY_RST;
            gen_mem[init_cnt_reg[IW-1:0]] <= '0;
            alloc_mem[init_cnt_reg[IW-1:0]] <= 1'b0;
        end else if (cmd.commit) begin
            if (is_alloc && !nofree_reg) begin
                entry_mem[tgt] <= '{etype: type_reg, eflag: flag_reg, hop: 8'd0,
                    loc_type: 3'd0, loc_id: 16'hFFFF, slot: 16'hFFFF};
                alloc_mem[tgt] <= 1'b1;
            end else if (rel_ok) begin
                entry_mem[tgt] <= '{etype: ent_rd_reg.etype, eflag: ent_rd_reg.eflag,
                    hop: ent_rd_reg.hop, loc_type: 3'd0, loc_id: 16'hFFFF,
                    slot: 16'hFFFF};
                gen_mem[tgt] <= gen_rd_reg + 16'd1;
                alloc_mem[tgt] <= 1'b0;
                if (free_reg < (IW+1)'(active_reg)) stack_mem[free_reg[IW-1:0]] <= tgt;
            end else if (op_reg == ridat_pkg::OP_SETLOC && !bad_reg) begin
                entry_mem[tgt] <= '{etype: ent_rd_reg.etype, eflag: ent_rd_reg.eflag,
                    hop: ent_rd_reg.hop, loc_type: lt_reg, loc_id: lid_reg,
                    slot: slot_reg};
            end
        end
        if (cmd.rd) begin
            ent_rd_reg <= entry_mem[tgt];
            gen_rd_reg <= gen_mem[tgt];
            alloc_rd_reg <= alloc_mem[tgt];
        end
        if (cmd.load) pop_rd_reg <= stack_mem[free_m1[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.init_start) begin
            free_reg <= '0;
        end else if (cmd.init_step) begin
            free_reg <= (IW+1)'(active_reg);
        end else if (cmd.commit) begin
            if (is_alloc && !nofree_reg) begin
                free_reg <= free_m1;
            end else if (rel_ok) begin
                if (free_reg < (IW+1)'(active_reg)) free_reg <= free_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) clr_cnt_reg <= '0;
        else if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_op;
            rid_reg <= in_rid;
            type_reg <= in_type;
            flag_reg <= in_flag;
            lt_reg <= in_lt;
            lid_reg <= in_lid;
            slot_reg <= in_slot;
            widx_reg <= in_widx;
            wdata_reg <= in_wdata;
            id_reg <= IW'(in_rid[6:0]);
            bad_reg <= (in_op > ridat_pkg::OP_PREAD) || in_rid[7] ||
                       ({1'b0, in_rid} >= {2'b0, active_reg});
            nofree_reg <= (free_reg == '0) || (free_reg > (IW+1)'(active_reg));
            widx_bad_reg <= ({1'b0, in_widx} >= pwords_reg);
        end
    end

    // result, built from values read before commit
    always_comb begin
        status_next = ridat_pkg::ST_OK;
        rid_next = rid_reg[6:0];
        entry_next = '0;
        gen_next = '0;
        alloc_next = 1'b0;
        rdata_next = '0;
        if (is_alloc) begin
            if (nofree_reg) begin
                status_next = ridat_pkg::ST_NOFREE;
                rid_next = 7'h7F;
            end else begin
                rid_next = 7'(tgt);
                entry_next = '{etype: type_reg, eflag: flag_reg, hop: 8'd0,
                    loc_type: 3'd0, loc_id: 16'hFFFF, slot: 16'hFFFF};
                gen_next = gen_rd_reg;
                alloc_next = 1'b1;
            end
        end else if (bad_reg) begin
            status_next = ridat_pkg::ST_RANGE;
        end else begin
            entry_next = ent_rd_reg;
            gen_next = gen_rd_reg;
            alloc_next = alloc_rd_reg;
            case (op_reg)
                ridat_pkg::OP_RELEASE: begin
                    if (!alloc_rd_reg) begin
                        status_next = ridat_pkg::ST_FREEREL;
                    end else begin
                        entry_next.loc_type = 3'd0;
                        entry_next.loc_id = 16'hFFFF;
                        entry_next.slot = 16'hFFFF;
                        gen_next = gen_rd_reg + 16'd1;
                        alloc_next = 1'b0;
                    end
                end
                ridat_pkg::OP_SETLOC: begin
                    entry_next.loc_type = lt_reg;
                    entry_next.loc_id = lid_reg;
                    entry_next.slot = slot_reg;
                    if (!ridat_pkg::inv_ok(lt_reg, lid_reg, slot_reg))
                        status_next = ridat_pkg::ST_INVAR;
                end
                ridat_pkg::OP_PWRITE: begin
                    if (widx_bad_reg) status_next = ridat_pkg::ST_RANGE;
                end
                ridat_pkg::OP_PREAD: begin
                    if (widx_bad_reg) status_next = ridat_pkg::ST_RANGE;
                    else rdata_next = pay_rd_reg;
                end
                default: status_next = ridat_pkg::ST_OK;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_status <= status_next;
            o_rid <= rid_next;
            o_entry <= entry_next;
            o_gen <= gen_next;
            o_alloc <= alloc_next;
            o_rdata <= rdata_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> free_reg <= (IW+1)'(active_reg)) else $error("free count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && is_alloc && !nofree_reg && !cfg_wr) |=> alloc_mem[$past(tgt)])
        else $error("allocated id not marked");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && rel_ok && !cfg_wr) |=> !alloc_mem[$past(tgt)])
        else $error("released id still marked");

endmodule

>>> hw/rtl/request_id_allocator_table.sv
`timescale 1ns / 1ps
// Request-ID table with a LIFO free list. One word is processed at a time:
// a capture, registered memory reads, an execute state and an output state;
// the result is formed and registered in the execute state. A successful
// allocate or release then also clears the configured number of payload
// words one per cycle through the single payload memory port before the
// output state. The result is held in an output register and the next word
// is accepted the cycle after the result has been taken. After reset and
// after every configuration write a clearing pass sweeps all ID_COUNT *
// 2^ceil(log2 MAX_PAYLOAD_WORDS) payload words (512 at defaults) and the
// other memories and rebuilds the free list; no word is taken during it.
module request_id_allocator_table #(
    parameter int ID_COUNT          = ridat_pkg::MAX_REQUESTS_DEF,
    parameter int MAX_PAYLOAD_WORDS = ridat_pkg::MAX_PAYLOAD_WORDS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op, req id, type id, flag, loc type, loc id, slot id,
    // word index, write data, zero fill
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, result id, entry type, entry flag, entry hop, entry loc type,
    // entry loc id, entry slot id, entry generation, entry allocated,
    // read data, zero fill
    output logic [127:0] m_tdata
);

    ridat_pkg::ridat_cmd_t cmd;
    ridat_pkg::ridat_sts_t sts;
    ridat_pkg::entry_t     ent;
    logic [2:0]  st;
    logic [6:0]  rid;
    logic [15:0] gen;
    logic        alc;
    logic [31:0] rdata;
    logic        s_fire, out_set, mvalid_reg;

    assign cfg_ready = 1'b1;
    assign s_fire = s_tvalid && s_tready;

    ridat_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr(cfg_valid), .s_fire(s_fire),
        .m_busy(mvalid_reg), .sts(sts), .cmd(cmd), .s_ready(s_tready),
        .out_set(out_set)
    );

    ridat_dp #(.ID_COUNT(ID_COUNT), .MAX_PAYLOAD_WORDS(MAX_PAYLOAD_WORDS)) u_dp (
        .aclk(aclk), .cfg_wr(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
        .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_op(s_tdata[2:0]), .in_rid(s_tdata[10:3]), .in_type(s_tdata[18:11]),
        .in_flag(s_tdata[26:19]), .in_lt(s_tdata[29:27]), .in_lid(s_tdata[45:30]),
        .in_slot(s_tdata[61:46]), .in_widx(s_tdata[64:62]),
        .in_wdata(s_tdata[96:65]),
        .o_status(st), .o_rid(rid), .o_entry(ent), .o_gen(gen), .o_alloc(alc),
        .o_rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (out_set) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata = {10'd0, rdata, alc, gen, ent.slot, ent.loc_id, ent.loc_type,
                      ent.hop, ent.eflag, ent.etype, rid, st};

endmodule
